### rtl/bda_pkg.sv
package bda_pkg;

  // button mode codes
  localparam logic [2:0] MODE_IDLE         = 3'd0;
  localparam logic [2:0] MODE_DEBOUNCE     = 3'd1;
  localparam logic [2:0] MODE_JUST_PRESS   = 3'd2;
  localparam logic [2:0] MODE_PRESS        = 3'd3;
  localparam logic [2:0] MODE_JUST_RELEASE = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIN_INDEX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_VALUE = 3'd4;

  localparam logic [7:0] DEBOUNCE_MS_RST = 8'd50;

  // one result word
  typedef struct packed {
    logic               fire;
    logic signed [15:0] fire_value;
    logic               idle;
    logic               level;
    logic [2:0]         mode;
  } result_t;

endpackage

### rtl/bda_if.sv
interface bda_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pin_bits;
  logic [31:0] now_ms;

  modport source (output valid, output pin_bits, output now_ms, input ready);
  modport sink   (input valid, input pin_bits, input now_ms, output ready);
endinterface

interface bda_out_if;
  logic               valid;
  logic               ready;
  logic               fire;
  logic signed [15:0] fire_value;
  logic               idle;
  logic               level;
  logic [2:0]         mode;

  modport source (output valid, output fire, output fire_value, output idle,
                  output level, output mode, input ready);
  modport sink   (input valid, input fire, input fire_value, input idle,
                  input level, input mode, output ready);
endinterface

### rtl/button_debounce_autorepeat_unit.sv
// an accepted input word passes through the input register, then the result
//   register; throughput: one word per cycle while the output takes words;
//   the input register and the result register let a new poll enter while a
//   finished result still waits on the output
// reset (synchronous, rst_n low): mode idle, level and last sample released,
//   deadline 0, debounce 50 ms, other config registers 0, both stages empty
module button_debounce_autorepeat_unit
  import bda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bda_in_if.sink                in_ch,
  bda_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [2:0]         pin_index_r;
  logic [7:0]         debounce_ms_r;
  logic [15:0]        press_delay_r;
  logic [15:0]        repeat_ms_r;
  logic signed [15:0] action_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_index_r    <= '0;
      debounce_ms_r  <= DEBOUNCE_MS_RST;
      press_delay_r  <= '0;
      repeat_ms_r    <= '0;
      action_value_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIN_INDEX:    pin_index_r    <= cfg_wdata[2:0];
        CFG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_wdata[7:0];
        CFG_PRESS_DELAY:  press_delay_r  <= cfg_wdata;
        CFG_REPEAT_MS:    repeat_ms_r    <= cfg_wdata;
        CFG_ACTION_VALUE: action_value_r <= cfg_wdata;
        default: ; // indexes past the list are dropped
      endcase
    end
  end

  // input register stage
  logic        s1_valid_r;
  logic [7:0]  s1_pins_r;
  logic [31:0] s1_now_r;
  logic        advance;

  // result register stage
  logic    out_valid_r;
  result_t out_r;
  result_t res_nxt;

  // button state
  logic        level_r, level_nxt;
  logic        last_r;
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] deadline_r, deadline_nxt;

  // stage 1 moves on when the result register is empty or being drained
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_pins_r <= in_ch.pin_bits;
      s1_now_r  <= in_ch.now_ms;
    end
  end

  // single pass step: one compare, adds in parallel, small mode update
  logic        sample;
  logic        passed;
  logic        do_fire;
  logic [31:0] dl_debounce;
  logic [31:0] dl_press;
  logic [31:0] dl_repeat;

  assign sample      = s1_pins_r[pin_index_r];
  assign passed      = (s1_now_r >= deadline_r);
  assign dl_debounce = s1_now_r + {24'd0, debounce_ms_r};
  assign dl_press    = deadline_r + {16'd0, press_delay_r};
  assign dl_repeat   = deadline_r + {16'd0, repeat_ms_r};

  always_comb begin
    level_nxt    = level_r;
    mode_nxt     = mode_r;
    deadline_nxt = deadline_r;
    do_fire      = 1'b0;
    if (sample != last_r) begin
      // any edge on the raw sample restarts the stability window
      mode_nxt     = MODE_DEBOUNCE;
      deadline_nxt = dl_debounce;
    end else if (passed) begin
      if (mode_r == MODE_DEBOUNCE) begin
        level_nxt = sample;
        if (!sample) begin
          mode_nxt = MODE_JUST_RELEASE;
        end else begin
          mode_nxt = MODE_JUST_PRESS;
          // long press delay pushes the first fire out
          if (press_delay_r != '0) deadline_nxt = dl_press;
          else                     do_fire      = 1'b1;
        end
      end else if (mode_r == MODE_JUST_PRESS) begin
        do_fire = 1'b1;
      end
      if (do_fire) begin
        // press and repeat delays never add on the same poll
        if (repeat_ms_r != '0) deadline_nxt = dl_repeat;
        else                   mode_nxt     = MODE_PRESS;
      end
    end
  end

  always_comb begin
    res_nxt.fire       = do_fire;
    res_nxt.fire_value = do_fire ? action_value_r : '0;
    res_nxt.idle       = (mode_nxt == MODE_IDLE) || (mode_nxt == MODE_JUST_RELEASE);
    res_nxt.level      = level_nxt;
    res_nxt.mode       = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= 1'b0;
      last_r     <= 1'b0;
      mode_r     <= MODE_IDLE;
      deadline_r <= '0;
    end else if (advance) begin
      level_r    <= level_nxt;
      last_r     <= sample;
      mode_r     <= mode_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= res_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fire       = out_r.fire;
  assign out_ch.fire_value = out_r.fire_value;
  assign out_ch.idle       = out_r.idle;
  assign out_ch.level      = out_r.level;
  assign out_ch.mode       = out_r.mode;

  // a fire word always leaves the button in a pressed mode
  a_fire_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fire |->
      (out_r.mode == MODE_JUST_PRESS) || (out_r.mode == MODE_PRESS))
    else $error("fire word with a mode that is not pressed");

  // pressed modes are only reached through a debounced press
  a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_JUST_PRESS) || (mode_r == MODE_PRESS) |-> level_r)
    else $error("pressed mode with released level");

  // release mode only follows a debounced release
  a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_JUST_RELEASE) |-> !level_r)
    else $error("release mode with pressed level");

  // button state moves only when a poll passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(mode_r) && $stable(deadline_r) && $stable(last_r))
    else $error("button state changed without a poll");

endmodule
